// File: src/rcfp_pkg.sv
// Package for the remote-control frame parser: frame constants, status codes,
// the frame summary struct and the CRC-16/MCRF4XX byte update function.
// No dependencies.
`default_nettype none

package rcfp_pkg;

    localparam int FRAME_LEN = 21;
    localparam int STORE_LEN = 17;
    localparam int COUNT_W   = 5;
    localparam int STORE_OFS = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 5'd31;
    localparam logic [COUNT_W-1:0] COUNT_FRAME = 5'd21;
    localparam logic [7:0]         HEAD_0      = 8'hA9;
    localparam logic [7:0]         HEAD_1      = 8'h53;
    localparam logic [15:0]        CRC_INIT    = 16'hFFFF;
    localparam logic [15:0]        CRC_POLY    = 16'h8408;
    localparam logic [10:0]        CENTRE      = 11'd1024;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_LEN = 2'd1,
        ST_HDR = 2'd2,
        ST_CRC = 2'd3
    } status_t;

    typedef logic [STORE_LEN-1:0][7:0] payload_t;

    typedef struct packed {
        logic    done;
        status_t status;
    } frame_sum_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/rcfp_in_if.sv
// Input channel of the frame parser: one frame byte per item with a last flag.
// No dependencies.
`default_nettype none

interface rcfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// File: src/rcfp_out_if.sv
// Result channel of the frame parser: status and decoded frame fields.
// No dependencies.
`default_nettype none

interface rcfp_out_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [10:0] stick_right_h;
    logic signed [10:0] stick_right_v;
    logic signed [10:0] stick_left_v;
    logic signed [10:0] stick_left_h;
    logic signed [10:0] wheel_pos;
    logic        [5:0]  switch_bits;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic signed [15:0] mouse_dz;
    logic        [5:0]  mouse_buttons;
    logic        [15:0] key_mask;

    modport source (
        output valid, input ready, output status,
        output stick_right_h, output stick_right_v, output stick_left_v,
        output stick_left_h, output wheel_pos, output switch_bits,
        output mouse_dx, output mouse_dy, output mouse_dz,
        output mouse_buttons, output key_mask
    );
    modport sink (
        input valid, output ready, input status,
        input stick_right_h, input stick_right_v, input stick_left_v,
        input stick_left_h, input wheel_pos, input switch_bits,
        input mouse_dx, input mouse_dy, input mouse_dz,
        input mouse_buttons, input key_mask
    );
endinterface

`default_nettype wire

// File: src/rcfp_accum.sv
// Per-byte frame state: byte counter, running CRC, header check and payload
// store; reports the frame status when the last byte is taken. Uses rcfp_pkg.
`default_nettype none

module rcfp_accum (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          data_byte,
    input  wire logic                frame_end,
    output rcfp_pkg::frame_sum_t     frame_sum,
    output rcfp_pkg::payload_t       payload
);
    import rcfp_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    logic [15:0]        crc_reg;
    logic [15:0]        crc_next;
    logic [15:0]        crc_upd;
    logic               header_ok_reg;
    logic               header_ok_next;
    logic               header_upd;
    payload_t           store_reg;
    status_t            status;

    always_comb
    begin
        count_inc  = (count_reg < COUNT_MAX) ? count_reg + 5'd1 : count_reg;
        crc_upd    = crc_byte(crc_reg, data_byte);
        header_upd = header_ok_reg
                     && !(count_reg == 5'd0 && data_byte != HEAD_0)
                     && !(count_reg == 5'd1 && data_byte != HEAD_1);

        if (count_inc != COUNT_FRAME)
        begin
            status = ST_LEN;
        end
        else if (!header_upd)
        begin
            status = ST_HDR;
        end
        else if (crc_upd != 16'h0000)
        begin
            status = ST_CRC;
        end
        else
        begin
            status = ST_OK;
        end

        count_next     = count_reg;
        crc_next       = crc_reg;
        header_ok_next = header_ok_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                count_next     = '0;
                crc_next       = CRC_INIT;
                header_ok_next = 1'b1;
            end
            else
            begin
                count_next     = count_inc;
                crc_next       = crc_upd;
                header_ok_next = header_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            crc_reg       <= CRC_INIT;
            header_ok_reg <= 1'b1;
        end
        else
        begin
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            header_ok_reg <= header_ok_next;
        end
    end

    // Frame bytes 2 to 18 land in the store; each entry has a fixed index.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_LEN; i++) begin
            if (accept && count_reg == COUNT_W'(i + STORE_OFS))
            begin
                store_reg[i] <= data_byte;
            end
        end
    end

    assign frame_sum.done   = accept && frame_end;
    assign frame_sum.status = status;
    assign payload          = store_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_end) |=> (count_reg == '0 && crc_reg == CRC_INIT && header_ok_reg))
        else $error("frame state not restarted after the last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !frame_end && count_reg == COUNT_MAX) |=> (count_reg == COUNT_MAX))
        else $error("byte counter did not saturate");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!accept) |=> ($stable(count_reg) && $stable(crc_reg) && $stable(header_ok_reg)))
        else $error("frame state changed without an accepted item");

endmodule

`default_nettype wire

// File: src/rcfp_result.sv
// Result stage: decodes the stored payload into the output fields and holds
// the result item in a register until taken. Uses rcfp_pkg and rcfp_out_if.
`default_nettype none

module rcfp_result (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rcfp_pkg::frame_sum_t frame_sum,
    input  wire rcfp_pkg::payload_t   payload,
    output logic                      can_take,
    rcfp_out_if.source                res
);
    import rcfp_pkg::*;

    logic [63:0] bits;
    logic        good;
    logic        res_valid_reg;
    logic        res_valid_next;
    status_t     status_reg;
    logic [10:0] srh_reg;
    logic [10:0] srv_reg;
    logic [10:0] slv_reg;
    logic [10:0] slh_reg;
    logic [10:0] wheel_reg;
    logic [5:0]  switch_reg;
    logic [15:0] dx_reg;
    logic [15:0] dy_reg;
    logic [15:0] dz_reg;
    logic [5:0]  buttons_reg;
    logic [15:0] keys_reg;

    assign bits     = payload[7:0];
    assign good     = (frame_sum.status == ST_OK);
    assign can_take = !res_valid_reg || res.ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (frame_sum.done)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_sum.done)
        begin
            status_reg  <= frame_sum.status;
            srh_reg     <= good ? bits[10:0]  - CENTRE : '0;
            srv_reg     <= good ? bits[21:11] - CENTRE : '0;
            slv_reg     <= good ? bits[32:22] - CENTRE : '0;
            slh_reg     <= good ? bits[43:33] - CENTRE : '0;
            wheel_reg   <= good ? bits[59:49] - CENTRE : '0;
            switch_reg  <= good ? {bits[60], bits[48:44]} : '0;
            dx_reg      <= good ? {payload[9], payload[8]} : '0;
            dy_reg      <= good ? {payload[11], payload[10]} : '0;
            dz_reg      <= good ? {payload[13], payload[12]} : '0;
            buttons_reg <= good ? payload[14][5:0] : '0;
            keys_reg    <= good ? {payload[16], payload[15]} : '0;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.status        = status_reg;
    assign res.stick_right_h = $signed(srh_reg);
    assign res.stick_right_v = $signed(srv_reg);
    assign res.stick_left_v  = $signed(slv_reg);
    assign res.stick_left_h  = $signed(slh_reg);
    assign res.wheel_pos     = $signed(wheel_reg);
    assign res.switch_bits   = switch_reg;
    assign res.mouse_dx      = $signed(dx_reg);
    assign res.mouse_dy      = $signed(dy_reg);
    assign res.mouse_dz      = $signed(dz_reg);
    assign res.mouse_buttons = buttons_reg;
    assign res.key_mask      = keys_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && status_reg != ST_OK) |->
            (keys_reg == '0 && dx_reg == '0 && dy_reg == '0 && dz_reg == '0
             && srh_reg == '0 && wheel_reg == '0 && switch_reg == '0 && buttons_reg == '0))
        else $error("error result carries nonzero data");

    assert property (@(posedge clk) disable iff (!rst_n)
        frame_sum.done |=> res_valid_reg)
        else $error("last byte did not produce a result item");

    assert property (@(posedge clk) disable iff (!rst_n)
        frame_sum.done |-> can_take)
        else $error("frame ended while the result register was blocked");

endmodule

`default_nettype wire

// File: src/rc_frame_parser_crc16.sv
// Top level of the remote-control frame parser with CRC-16/MCRF4XX check.
// Uses rcfp_pkg, rcfp_in_if, rcfp_out_if, rcfp_accum and rcfp_result.
//
//   Channel     Dir   Item
//   byte_in     in    data_byte[7:0], frame_end
//   result_out  out   status[1:0], sticks, wheel, switches, mouse, keys
//
// One byte is taken per cycle unless input is held off; the result of a frame is registered
// and appears in the cycle after its last byte. CRC update, header check and store write act in the byte's cycle.
// Reset clears the byte counter, sets the CRC to FFFF and drops the result.
// Input is held off only while a result waits and the sink is not ready.
`default_nettype none

module rc_frame_parser_crc16 (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rcfp_in_if.sink     byte_in,
    rcfp_out_if.source  result_out
);
    import rcfp_pkg::*;

    logic       can_take;
    logic       accept;
    frame_sum_t frame_sum;
    payload_t   payload;

    assign byte_in.ready = can_take;
    assign accept        = byte_in.valid && can_take;

    rcfp_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (byte_in.data_byte),
        .frame_end (byte_in.frame_end),
        .frame_sum (frame_sum),
        .payload   (payload)
    );

    rcfp_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_sum (frame_sum),
        .payload   (payload),
        .can_take  (can_take),
        .res       (result_out)
    );

endmodule

`default_nettype wire

// File: tb/tb_rc_frame_parser_crc16.sv
// Self-checking testbench for rc_frame_parser_crc16: directed frames, then random frames under
// several idle and stall patterns, each result checked against a table row or local decoder.
// Depends on rcfp_pkg, rcfp_in_if, rcfp_out_if and the rc_frame_parser_crc16 RTL.

module tb_rc_frame_parser_crc16;

    import rcfp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 880;
    localparam int NUM_PHASES   = 4;
    localparam int NUM_ROWS     = 17;
    localparam int DRAIN_CYCLES = 4;

    localparam int IDLE_PCT  [NUM_PHASES] = '{0, 82, 0, 36};
    localparam int STALL_PCT [NUM_PHASES] = '{0, 0, 82, 36};

    typedef struct packed {
        status_t            status;
        logic signed [10:0] stick_rh;
        logic signed [10:0] stick_rv;
        logic signed [10:0] stick_lv;
        logic signed [10:0] stick_lh;
        logic signed [10:0] wheel;
        logic        [5:0]  switches;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic        [5:0]  buttons;
        logic        [15:0] keys;
    } rc_result_t;

    typedef struct packed {
        logic [5:0]  len;
        logic [7:0]  head0;
        logic [7:0]  head1;
        logic [63:0] bits;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
        logic [7:0]  buttons;
        logic [15:0] keys;
        logic [15:0] crc_flip;
        logic        typed;
        rc_result_t  exp;
    } frame_row_t;

    localparam rc_result_t RES_NONE = '0;
    localparam rc_result_t RES_LEN  = '{status: ST_LEN, default: '0};
    localparam rc_result_t RES_HDR  = '{status: ST_HDR, default: '0};
    localparam rc_result_t RES_CRC  = '{status: ST_CRC, default: '0};
    localparam rc_result_t RES_LOW  = '{status: ST_OK, stick_rh: 11'h400, stick_rv: 11'h400,
                                        stick_lv: 11'h400, stick_lh: 11'h400, wheel: 11'h400,
                                        default: '0};
    localparam rc_result_t RES_HIGH = '{status: ST_OK, stick_rh: 11'h3FF, stick_rv: 11'h3FF,
                                        stick_lv: 11'h3FF, stick_lh: 11'h3FF, wheel: 11'h3FF,
                                        default: '1};

    localparam frame_row_t FRAME_TABLE [NUM_ROWS] = '{
        '{6'd21, HEAD_0, HEAD_1, 64'h0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000,
          16'h0000, 1'b1, RES_LOW},
        '{6'd21, HEAD_0, HEAD_1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF,
          16'h0000, 1'b1, RES_HIGH},
        '{6'd21, HEAD_0, HEAD_1, 64'hA5A5_5A5A_F00F_0FF0, 16'h8000, 16'h7FFF, 16'h0001, 8'hC0,
          16'h8001, 16'h0000, 1'b0, RES_NONE},
        '{6'd21, HEAD_0, HEAD_1, 64'h1001_F000_0000_0000, 16'h0001, 16'h8000, 16'h7FFF, 8'h15,
          16'h0001, 16'h0000, 1'b0, RES_NONE},
        '{6'd21, 8'h00, HEAD_1, 64'h0123_4567_89AB_CDEF, 16'h1234, 16'h5678, 16'h9ABC, 8'h3F,
          16'hFFFF, 16'h0000, 1'b1, RES_HDR},
        '{6'd21, HEAD_0, 8'h52, 64'h0123_4567_89AB_CDEF, 16'h1234, 16'h5678, 16'h9ABC, 8'h3F,
          16'hFFFF, 16'h0000, 1'b1, RES_HDR},
        '{6'd21, HEAD_1, HEAD_0, 64'hFFFF_0000_FFFF_0000, 16'h0000, 16'h0000, 16'h0000, 8'h00,
          16'h0000, 16'h0000, 1'b1, RES_HDR},
        '{6'd21, HEAD_0, HEAD_1, 64'hDEAD_BEEF_0BAD_F00D, 16'h0101, 16'h0202, 16'h0303, 8'h04,
          16'h0505, 16'h0001, 1'b1, RES_CRC},
        '{6'd21, HEAD_0, HEAD_1, 64'hDEAD_BEEF_0BAD_F00D, 16'h0101, 16'h0202, 16'h0303, 8'h04,
          16'h0505, 16'h8000, 1'b1, RES_CRC},
        '{6'd20, HEAD_0, HEAD_1, 64'h0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000,
          16'h0000, 1'b1, RES_LEN},
        '{6'd22, HEAD_0, HEAD_1, 64'h0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000,
          16'h0000, 1'b1, RES_LEN},
        '{6'd1, HEAD_0, HEAD_1, 64'h0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000,
          16'h0000, 1'b1, RES_LEN},
        '{6'd20, 8'hFF, 8'h00, 64'h0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000,
          16'h0000, 1'b1, RES_LEN},
        '{6'd21, 8'hA8, HEAD_1, 64'h0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000,
          16'h0F0F, 1'b1, RES_HDR},
        '{6'd31, HEAD_0, HEAD_1, 64'h0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000,
          16'h0000, 1'b1, RES_LEN},
        '{6'd53, HEAD_0, HEAD_1, 64'h0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000,
          16'h0000, 1'b1, RES_LEN},
        '{6'd21, HEAD_0, HEAD_1, 64'h0123_4567_89AB_CDEF, 16'hFEDC, 16'hBA98, 16'h7654, 8'h2A,
          16'h3210, 16'h0000, 1'b0, RES_NONE}
    };

    logic clk;
    logic rst_n;

    rcfp_in_if  in_ch ();
    rcfp_out_if out_ch ();

    rc_frame_parser_crc16 DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (in_ch),
        .result_out (out_ch)
    );

    logic [4:0]  frame_count   = '0;
    logic [15:0] frame_crc     = CRC_INIT;
    logic        header_good   = 1'b1;
    logic [7:0]  payload_bytes [STORE_LEN] = '{default: 8'h00};

    rc_result_t pending_results [$];
    frame_row_t directed_rows [$];

    int mismatches     = 0;
    int cycle_count    = 0;
    int bytes_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [15:0] crc16_mcrf(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc;
        for (int k = 0; k < 8; k++)
        begin
            r = (r[0] ^ b[k]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last);
        rc_result_t  r;
        logic [63:0] bits;
        frame_row_t  row;
        if (frame_count == 5'd0 && b != HEAD_0)
        begin
            header_good = 1'b0;
        end
        if (frame_count == 5'd1 && b != HEAD_1)
        begin
            header_good = 1'b0;
        end
        if (frame_count >= STORE_OFS && frame_count < STORE_OFS + STORE_LEN)
        begin
            payload_bytes[frame_count - STORE_OFS] = b;
        end
        frame_crc = crc16_mcrf(frame_crc, b);
        if (frame_count != COUNT_MAX)
        begin
            frame_count = frame_count + 5'd1;
        end
        if (last)
        begin
            r = '0;
            if (frame_count != COUNT_FRAME)
            begin
                r.status = ST_LEN;
            end
            else if (!header_good)
            begin
                r.status = ST_HDR;
            end
            else if (frame_crc != 16'h0000)
            begin
                r.status = ST_CRC;
            end
            else
            begin
                for (int i = 0; i < 8; i++)
                begin
                    bits[8*i +: 8] = payload_bytes[i];
                end
                r.status   = ST_OK;
                r.stick_rh = bits[10:0] - CENTRE;
                r.stick_rv = bits[21:11] - CENTRE;
                r.stick_lv = bits[32:22] - CENTRE;
                r.stick_lh = bits[43:33] - CENTRE;
                r.wheel    = bits[59:49] - CENTRE;
                r.switches = {bits[60], bits[48:44]};
                r.dx       = {payload_bytes[9], payload_bytes[8]};
                r.dy       = {payload_bytes[11], payload_bytes[10]};
                r.dz       = {payload_bytes[13], payload_bytes[12]};
                r.buttons  = payload_bytes[14][5:0];
                r.keys     = {payload_bytes[16], payload_bytes[15]};
            end
            if (directed_rows.size() != 0)
            begin
                row = directed_rows.pop_front();
                if (row.typed)
                begin
                    r = row.exp;
                end
            end
            pending_results.push_back(r);
            frame_count = '0;
            frame_crc   = CRC_INIT;
            header_good = 1'b1;
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result();
        rc_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result item arrived with no frame pending");
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            check_field("status", want.status, out_ch.status);
            check_field("stick_right_h", want.stick_rh, out_ch.stick_right_h);
            check_field("stick_right_v", want.stick_rv, out_ch.stick_right_v);
            check_field("stick_left_v", want.stick_lv, out_ch.stick_left_v);
            check_field("stick_left_h", want.stick_lh, out_ch.stick_left_h);
            check_field("wheel_pos", want.wheel, out_ch.wheel_pos);
            check_field("switch_bits", want.switches, out_ch.switch_bits);
            check_field("mouse_dx", want.dx, out_ch.mouse_dx);
            check_field("mouse_dy", want.dy, out_ch.mouse_dy);
            check_field("mouse_dz", want.dz, out_ch.mouse_dz);
            check_field("mouse_buttons", want.buttons, out_ch.mouse_buttons);
            check_field("key_mask", want.keys, out_ch.key_mask);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            parse_byte(in_ch.data_byte, in_ch.frame_end);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            check_result();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL rc_frame_parser_crc16");
            $finish;
        end
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.frame_end <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_row_t row);
        logic [7:0]  fb [FRAME_LEN];
        logic [15:0] c;
        fb[0] = row.head0;
        fb[1] = row.head1;
        for (int i = 0; i < 8; i++)
        begin
            fb[2 + i] = row.bits[8*i +: 8];
        end
        {fb[11], fb[10]} = row.dx;
        {fb[13], fb[12]} = row.dy;
        {fb[15], fb[14]} = row.dz;
        fb[16] = row.buttons;
        {fb[18], fb[17]} = row.keys;
        c = CRC_INIT;
        for (int i = 0; i < FRAME_LEN - 2; i++)
        begin
            c = crc16_mcrf(c, fb[i]);
        end
        c = c ^ row.crc_flip;
        {fb[20], fb[19]} = c;
        for (int n = 0; n < row.len; n++)
        begin
            if (n < FRAME_LEN)
            begin
                send_byte(fb[n], n == row.len - 1);
            end
            else
            begin
                send_byte(8'($urandom), n == row.len - 1);
            end
        end
    endtask

    // Most frames are well formed with random content; the rest carry one defect or are
    // plain byte noise ending on a last-byte flag.
    task automatic send_random_frame();
        frame_row_t row;
        int         kind;
        int         n;
        row         = '0;
        row.len     = 6'(FRAME_LEN);
        row.head0   = HEAD_0;
        row.head1   = HEAD_1;
        row.bits    = {$urandom, $urandom};
        row.dx      = 16'($urandom);
        row.dy      = 16'($urandom);
        row.dz      = 16'($urandom);
        row.buttons = 8'($urandom);
        row.keys    = 16'($urandom);
        kind        = $urandom_range(99);
        if (kind < 8)
        begin
            if ($urandom_range(1) == 0)
            begin
                row.head0 = 8'($urandom);
            end
            else
            begin
                row.head1 = 8'($urandom);
            end
        end
        else if (kind < 16)
        begin
            row.crc_flip = 16'($urandom_range(1, 16'hFFFF));
        end
        else if (kind < 26)
        begin
            row.len = ($urandom_range(9) == 0) ? 6'($urandom_range(32, 63))
                                               : 6'($urandom_range(1, 31));
        end
        else if (kind < 36)
        begin
            row.bits = ($urandom_range(1) == 0) ? (row.bits | {$urandom, $urandom})
                                                : (row.bits & {$urandom, $urandom});
        end
        if (kind >= 92)
        begin
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++)
            begin
                send_byte(8'($urandom), (i == n - 1) || ($urandom_range(7) == 0));
            end
        end
        else
        begin
            send_frame(row);
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int phase_start;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.frame_end <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            directed_rows.push_back(FRAME_TABLE[i]);
            send_frame(FRAME_TABLE[i]);
        end
        drain_results();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            send_idle_pct  = IDLE_PCT[phase];
            recv_stall_pct = STALL_PCT[phase];
            phase_start    = bytes_sent;
            while (bytes_sent - phase_start < RANDOM_ITEMS / NUM_PHASES)
            begin
                send_random_frame();
            end
            drain_results();
        end

        if (mismatches == 0)
        begin
            $display("PASS rc_frame_parser_crc16");
        end
        else
        begin
            $display("FAIL rc_frame_parser_crc16");
        end
        $finish;
    end

endmodule
